// ----- src/base64_stream_encoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared concurrent assertion helpers for the encoder's port checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

// Assertion sampled on clk_i and disabled while rst_ni is low.
`define B64E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on clk_i that also holds during reset.
`define B64E_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Types, constants and the character alphabet shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [6:0] PadChar = 7'h3D;

  typedef enum logic [1:0] {
    PhGroup0 = 2'd0,
    PhGroup1 = 2'd1,
    PhGroup2 = 2'd2
  } phase_e;

  // One decoded input byte: up to four characters to send.
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
    logic            final_job;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Maps a 6-bit value to its base64 ASCII character.
  function automatic logic [6:0] enc6(logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = 7'h41 + w;
    end else if (v < 6'd52) begin
      c = 7'h47 + w;
    end else if (v < 6'd62) begin
      c = w - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/b64e_fifo.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short register queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire b64e_pkg::job_t    push_data_i,
  input  wire logic              pop_i,
  output b64e_pkg::job_t         head_o,
  output b64e_pkg::q_status_t    status_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/b64e_front.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts input bytes, tracks the group phase and builds character jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_final_i,
  output logic                   in_ready_o,
  input  wire b64e_pkg::q_status_t q_status_i,
  output logic                   push_o,
  output b64e_pkg::job_t         job_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] pend_q, pend_d;
  logic       accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    job_o     = '0;
    phase_d   = phase_q;
    pend_d    = pend_q;
    case (phase_q)
      PhGroup1: begin
        job_o.chars[0] = enc6({pend_q[1:0], in_byte_i[7:4]});
        if (in_final_i) begin
          job_o.chars[1]  = enc6({in_byte_i[3:0], 2'b00});
          job_o.chars[2]  = PadChar;
          job_o.last_idx  = 2'd2;
          job_o.final_job = 1'b1;
          pend_d          = '0;
          phase_d         = PhGroup0;
        end else begin
          pend_d  = in_byte_i[3:0];
          phase_d = PhGroup2;
        end
      end
      PhGroup2: begin
        job_o.chars[0]  = enc6({pend_q, in_byte_i[7:6]});
        job_o.chars[1]  = enc6(in_byte_i[5:0]);
        job_o.last_idx  = 2'd1;
        job_o.final_job = in_final_i;
        pend_d          = '0;
        phase_d         = PhGroup0;
      end
      default: begin
        job_o.chars[0] = enc6(in_byte_i[7:2]);
        if (in_final_i) begin
          job_o.chars[1]  = enc6({in_byte_i[1:0], 4'b0000});
          job_o.chars[2]  = PadChar;
          job_o.chars[3]  = PadChar;
          job_o.last_idx  = 2'd3;
          job_o.final_job = 1'b1;
          pend_d          = '0;
          phase_d         = PhGroup0;
        end else begin
          pend_d  = {2'b00, in_byte_i[1:0]};
          phase_d = PhGroup1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhGroup0;
      pend_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/b64e_back.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks the head job into output register, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire b64e_pkg::q_status_t q_status_i,
  input  wire b64e_pkg::job_t      head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  output logic [6:0]               out_char_o,
  output logic                     out_last_o,
  input  wire logic                out_ready_i
);
  import b64e_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       out_free, emit, job_done;

  assign out_free = !valid_q || out_ready_i;
  assign emit     = out_free && !q_status_i.empty;
  assign job_done = (idx_q == head_i.last_idx);
  assign pop_o    = emit && job_done;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (out_free) begin
      valid_d = !q_status_i.empty;
    end
    if (emit) begin
      char_d = head_i.chars[idx_q];
      last_d = head_i.final_job && job_done;
      idx_d  = job_done ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ----- src/base64_stream_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard base64 characters with '=' padding.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one message byte per transaction in
// s_axis_tdata_i, with s_axis_tlast_i set on the final byte of a message.
// The master stream carries one ASCII character per transaction in
// m_axis_tdata_o, with m_axis_tlast_o set on the final character.
// Each byte produces one to four characters: one or two inside a group,
// and on the final byte the flushed bits plus any '=' padding.
// The first character of a byte passes the job queue and then the back
// end's single output register. The output runs at one character per cycle
// while the receiver is ready and jobs are queued, and a byte is accepted
// in every cycle that the job queue has room.
// Reset clears the group phase, the pending bits, the job queue and the
// output valid flag; the next byte starts a new message.
// When the receiver stalls, the output register holds its character, the
// queue fills, and s_axis_tready_o drops until a job drains.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_unit #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [6:0] out_char, [7] zero fill
  output logic            m_axis_tlast_o
);
  import b64e_pkg::*;

  job_t      push_job, head_job;
  logic      push, pop;
  q_status_t q_status;
  logic [6:0] out_char;

  // Front end: classifies each byte by group phase into a character job.
  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_final_i (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  // The queue decouples byte intake from character output.
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .status_o    (q_status)
  );

  // Back end: sends the head job's characters one per cycle unless stalled.
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule

`default_nettype wire

// ----- src/b64e_checker.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder port checker
// Watches the encoder's ports and flags protocol or character errors.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_encoder_unit_defines.svh"

module b64e_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o
);

  logic out_in_alphabet;
  logic in_take;

  assign out_in_alphabet = (m_axis_tdata_o >= 8'h41 && m_axis_tdata_o <= 8'h5A) ||
                           (m_axis_tdata_o >= 8'h61 && m_axis_tdata_o <= 8'h7A) ||
                           (m_axis_tdata_o >= 8'h30 && m_axis_tdata_o <= 8'h39) ||
                           m_axis_tdata_o == 8'h2B || m_axis_tdata_o == 8'h2F ||
                           m_axis_tdata_o == 8'h3D;
  assign in_take = s_axis_tvalid_i && s_axis_tready_o;

  property p_out_hold;
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o);
  endproperty

  property p_latency;
    in_take && !m_axis_tvalid_o && $past(!m_axis_tvalid_o) &&
      $past(!in_take) && $past(!in_take, 2) |-> ##2 m_axis_tvalid_o;
  endproperty

  // A stalled output transaction keeps its character and marker.
  `B64E_ASSERT(a_out_hold, p_out_hold, "stalled output changed")

  // Every character sent is from the base64 alphabet or the pad character.
  `B64E_ASSERT(a_out_alphabet, m_axis_tvalid_o |-> out_in_alphabet, "character outside alphabet")

  // Output stays idle during reset and in the cycle after.
  `B64E_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "output valid right after reset")

  // From an empty pipeline, a byte reaches the output via queue and output reg.
  `B64E_ASSERT(a_latency, p_latency, "first character late")

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (.*);

`default_nettype wire

// ----- sim/base64_stream_encoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Feeds byte messages into the encoder and checks every output character.
// A short table of directed messages comes first. Some rows carry the
// encoded text typed in by hand and the others are checked against a
// behavioral encoder kept in this file. Random messages follow, with random
// idle cycles on both streams, one stretch with no idling, and a pause until
// every expected character has drained.
// ----------------------------------------------------------------------------

module base64_stream_encoder_unit_tb;

  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned RandomItems = 76;
  localparam int unsigned IdlePercent = 26;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxReports = 10;
  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One output character as the encoder should send it.
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } b64_char_t;

  // One directed row: a message byte, its end flag and, where it is
  // obvious, the characters it must produce. An empty string means that
  // the behavioral encoder decides.
  typedef struct {
    logic [7:0] data;
    logic       fin;
    string      text;
  } byte_vector_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [6:0] out_char, [7] zero fill
  logic       m_axis_tlast_o;

  // Behavioral encoder state: position in the 3-byte group and the bits
  // of the group that are not yet encoded.
  b64e_pkg::phase_e group_pos = b64e_pkg::PhGroup0;
  logic [3:0]       carry_bits = 4'h0;

  b64_char_t    exp_chars[$];
  byte_vector_t directed_rows[$];

  bit          no_idle = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned pads_checked = 0;
  int unsigned mismatches = 0;

  base64_stream_encoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Maps a 6-bit value to its character of the standard alphabet.
  function automatic logic [6:0] b64_code(input logic [5:0] v);
    byte c;
    c = Alphabet[v];
    return c[6:0];
  endfunction

  // Encodes one message byte: returns the characters that it completes,
  // plus the flush and any padding when it ends the message, and moves
  // the group state on.
  task automatic encode_byte(input logic [7:0] b, input logic fin,
                             output b64_char_t chars[4], output int count);
    case (group_pos)
      b64e_pkg::PhGroup1: begin
        chars[0] = '{b64_code({carry_bits[1:0], b[7:4]}), 1'b0};
        if (fin) begin
          chars[1] = '{b64_code({b[3:0], 2'b00}), 1'b0};
          chars[2] = '{b64e_pkg::PadChar, 1'b1};
          count = 3;
          carry_bits = 4'h0;
          group_pos = b64e_pkg::PhGroup0;
        end else begin
          count = 1;
          carry_bits = b[3:0];
          group_pos = b64e_pkg::PhGroup2;
        end
      end
      b64e_pkg::PhGroup2: begin
        // The group completes here, so the end flag only marks the last
        // character and no padding is needed.
        chars[0] = '{b64_code({carry_bits, b[7:6]}), 1'b0};
        chars[1] = '{b64_code(b[5:0]), fin};
        count = 2;
        carry_bits = 4'h0;
        group_pos = b64e_pkg::PhGroup0;
      end
      default: begin
        chars[0] = '{b64_code(b[7:2]), 1'b0};
        if (fin) begin
          chars[1] = '{b64_code({b[1:0], 4'h0}), 1'b0};
          chars[2] = '{b64e_pkg::PadChar, 1'b0};
          chars[3] = '{b64e_pkg::PadChar, 1'b1};
          count = 4;
          carry_bits = 4'h0;
          group_pos = b64e_pkg::PhGroup0;
        end else begin
          count = 1;
          carry_bits = {2'b00, b[1:0]};
          group_pos = b64e_pkg::PhGroup1;
        end
      end
    endcase
  endtask

  task automatic add_row(input logic [7:0] b, input logic fin, input string text);
    byte_vector_t row;
    row.data = b;
    row.fin = fin;
    row.text = text;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one byte on the slave stream and returns at the rising edge
  // that accepts it. Random idle cycles come first unless idling is off.
  // The handshake is sampled at the falling edge, when both sides have
  // settled for the coming rising edge.
  task automatic send_byte(input logic [7:0] b, input logic fin, input string text);
    b64_char_t chars[4];
    int        count;
    bit        taken;
    byte       c;
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= fin;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
    if (fin) begin
      messages_sent++;
    end
    // The encoder state always advances; hand-typed text, where a row has
    // it, replaces the computed characters.
    encode_byte(b, fin, chars, count);
    if (text.len() == 0) begin
      for (int i = 0; i < count; i++) begin
        exp_chars.insert(exp_chars.size(), chars[i]);
      end
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        c = text[i];
        exp_chars.insert(exp_chars.size(), '{c[6:0], fin && (i == text.len() - 1)});
      end
    end
  endtask

  // Holds the sender back until every expected character has come out.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (exp_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Receiver: stalls at random, except while the no-idle stretch runs.
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= IdlePercent);
  end

  // Result checker: a character counts as taken at the rising edge that
  // follows this falling edge, since the ready only changes at rising edges.
  always @(negedge clk_i) begin
    b64_char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("ERROR: unexpected character 0x%02h last=%0b at %0t",
                   m_axis_tdata_o, m_axis_tlast_o, $realtime);
        end
      end else begin
        want = exp_chars.pop_front();
        chars_checked++;
        if (want.code == b64e_pkg::PadChar) begin
          pads_checked++;
        end
        if (m_axis_tdata_o != {1'b0, want.code} || m_axis_tlast_o != want.last) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("ERROR: char %0d expected 0x%02h last=%0b, got 0x%02h last=%0b at %0t",
                     chars_checked, {1'b0, want.code}, want.last,
                     m_axis_tdata_o, m_axis_tlast_o, $realtime);
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned random_bytes;
    int unsigned msg_len;
    bit          drained_mid;
    drained_mid = 1'b0;

    // Directed table. Single-byte messages exercise the double padding,
    // two-byte ones the single pad, three-byte ones the unpadded flush.
    // All-zero and all-one bytes give the extremes of the alphabet, and
    // 0xF8 reaches the '+' character.
    add_row(8'h00, 1'b1, "AA==");
    add_row(8'hFF, 1'b1, "/w==");
    add_row(8'hF8, 1'b1, "+A==");
    add_row(8'h00, 1'b0, "A");
    add_row(8'h00, 1'b1, "AA=");
    add_row(8'hFF, 1'b0, "/");
    add_row(8'hFF, 1'b1, "/8=");
    add_row(8'h00, 1'b0, "A");
    add_row(8'h00, 1'b0, "A");
    add_row(8'h00, 1'b1, "AA");
    add_row(8'hFF, 1'b0, "/");
    add_row(8'hFF, 1'b0, "/");
    add_row(8'hFF, 1'b1, "//");
    add_row(8'h4D, 1'b0, "");
    add_row(8'h61, 1'b0, "");
    add_row(8'h6E, 1'b1, "");
    // A six-byte message runs a full group into a second one without a
    // break, then alternating bit patterns.
    add_row(8'h66, 1'b0, "");
    add_row(8'h6F, 1'b0, "");
    add_row(8'h6F, 1'b0, "");
    add_row(8'h62, 1'b0, "");
    add_row(8'h61, 1'b0, "");
    add_row(8'h72, 1'b1, "");
    add_row(8'h55, 1'b0, "");
    add_row(8'hAA, 1'b1, "");

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].text);
    end
    // The sender holds off here until the directed characters are all out.
    wait_drained();

    // Random messages, mostly short so that every group position and every
    // ending occurs often. A stretch in the middle runs with no idling on
    // either side, and one drain pause sits after it.
    random_bytes = 0;
    while (random_bytes < RandomItems) begin
      no_idle = (random_bytes >= 40) && (random_bytes < 65);
      if (!drained_mid && random_bytes >= 70) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      for (int unsigned j = 1; j <= msg_len; j++) begin
        send_byte(8'($urandom_range(255)), j == msg_len, "");
        random_bytes++;
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d messages; %0d characters checked, %0d of them pads.",
             bytes_sent, messages_sent, chars_checked, pads_checked);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
